// File: rtl/sida_pkg.sv
// Shared constants for the signed integer to decimal ASCII converter.
// No dependencies; used by every module of the block and by its checker.
package sida_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int BCD_DIGIT_W         = 4;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam logic [BCD_DIGIT_W-1:0] BCD_ADJ_LIMIT = 4'd5;
  localparam logic [BCD_DIGIT_W-1:0] BCD_ADJ_ADD   = 4'd3;

endpackage

// File: rtl/sida_dabble.sv
// Iterative binary to BCD unit (shift and add-3), one magnitude bit per cycle.
// Depends on sida_pkg for the BCD digit width and adjust constants.
module sida_dabble #(
  parameter int VALUE_WIDTH = sida_pkg::DEFAULT_VALUE_WIDTH,
  parameter int NDIG        = 10
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  input  logic [VALUE_WIDTH-1:0]                    mag,
  output logic                                      done,
  output logic [NDIG*sida_pkg::BCD_DIGIT_W-1:0]     bcd
);

  localparam int DW    = sida_pkg::BCD_DIGIT_W;
  localparam int BCD_W = NDIG * DW;
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [BCD_W-1:0]       adj;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;

  // add 3 to every digit of five or more before the shift
  for (genvar g = 0; g < NDIG; g++) begin : g_adj
    assign adj[g*DW +: DW] = (bcd_r[g*DW +: DW] >= sida_pkg::BCD_ADJ_LIMIT)
                             ? bcd_r[g*DW +: DW] + sida_pkg::BCD_ADJ_ADD
                             : bcd_r[g*DW +: DW];
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = mag;
      bcd_nxt  = '0;
      cnt_nxt  = CNT_W'(VALUE_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {adj[BCD_W-2:0], bin_r[VALUE_WIDTH-1]};
      bin_nxt = {bin_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

// File: rtl/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII converter.
// Depends on sida_pkg and instantiates sida_dabble.
//
// Usage:
//   Input channel (in_valid/in_ready/in_value): one two's complement integer
//   per item; only the low VALUE_WIDTH bits count, the top one being the sign.
//   Output channel (out_valid/out_ready/out_text_char/out_is_last): the
//   decimal text, most significant character first, one character per item.
//   A negative value opens with '-'; leading zeros are dropped and zero gives
//   a single '0'. out_is_last marks the final character of each value.
//   The most negative value converts exactly (magnitude held unsigned).
// Sequence:
//   in_ready is high only while the converter is idle. The accepting cycle
//   loads the shift-and-add-3 unit, which takes in the magnitude bit by bit;
//   its finished digits are then captured, the suppressed leading zeros are
//   dropped one by one in the skip state, and the characters (sign included)
//   follow in order, each as the output register frees.
// Reset (rst_n low, synchronous) empties the output register and returns the
// sequencer to idle. When the receiver stalls, the output register holds its
// character and the sequencer waits; the last character may wait there while
// the next value is already accepted.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = sida_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_text_char,
  output logic                   out_is_last
);

  localparam int DW     = sida_pkg::BCD_DIGIT_W;
  // digit count of 2^(VALUE_WIDTH-1): floor((w-1)*log10(2)) + 1
  localparam int NDIG   = (((VALUE_WIDTH - 1) * 1233) >> 12) + 1;
  localparam int BCD_W  = NDIG * DW;
  localparam int LEFT_W = $clog2(NDIG + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SKIP = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [BCD_W-1:0]       digits_r, digits_nxt;
  logic [LEFT_W-1:0]      left_r, left_nxt;
  logic                   neg_r, neg_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   dab_start;
  logic                   dab_done;
  logic [BCD_W-1:0]       dab_bcd;
  logic [VALUE_WIDTH-1:0] mag;
  logic [DW-1:0]          top_digit;
  logic                   load_ok;

  // magnitude as unsigned: the most negative value maps onto 2^(w-1)
  assign mag = in_value[VALUE_WIDTH-1]
               ? (~in_value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1})
               : in_value;

  assign top_digit = digits_r[BCD_W-1 -: DW];
  // output register free, or emptied at this edge
  assign load_ok   = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign dab_start = in_valid && in_ready;

  sida_dabble #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NDIG        (NDIG)
  ) u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dab_start),
    .mag   (mag),
    .done  (dab_done),
    .bcd   (dab_bcd)
  );

  always_comb begin
    state_nxt     = state_r;
    digits_nxt    = digits_r;
    left_nxt      = left_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          neg_nxt   = in_value[VALUE_WIDTH-1];
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        // capture the finished BCD word
        if (dab_done) begin
          digits_nxt = dab_bcd;
          left_nxt   = LEFT_W'(NDIG);
          state_nxt  = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros, but always keep the units digit
        if (top_digit == '0 && left_r != LEFT_W'(1)) begin
          digits_nxt = {digits_r[BCD_W-DW-1:0], {DW{1'b0}}};
          left_nxt   = left_r - LEFT_W'(1);
        end else begin
          state_nxt = neg_r ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = sida_pkg::CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        // advance one digit per free output slot
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = sida_pkg::CHAR_ZERO + {{(8-DW){1'b0}}, top_digit};
          out_last_nxt  = (left_r == LEFT_W'(1));
          digits_nxt    = {digits_r[BCD_W-DW-1:0], {DW{1'b0}}};
          left_nxt      = left_r - LEFT_W'(1);
          if (left_r == LEFT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    digits_r   <= digits_nxt;
    left_r     <= left_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_is_last   = out_last_r;

endmodule

// File: rtl/sida_checker.sv
// Port-level checker for signed_int_to_decimal_ascii, bound to the top level.
// Depends on sida_pkg for the character codes.
module sida_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_text_char,
  input logic       out_is_last
);

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_text_char) && $stable(out_is_last))
    else $error("output item changed while stalled");

  // only a sign or a decimal digit leaves the block
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_text_char == sida_pkg::CHAR_MINUS) ||
                  (out_text_char >= sida_pkg::CHAR_ZERO && out_text_char <= sida_pkg::CHAR_NINE))
    else $error("output character outside sign and digits");

  // a sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_char == sida_pkg::CHAR_MINUS |-> !out_is_last)
    else $error("sign flagged as last character");

  // one value at a time: ready drops after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a conversion is under way");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_text_char (out_text_char),
  .out_is_last   (out_is_last)
);

// File: sim/tb_top.sv
// Self-checking bench for signed_int_to_decimal_ascii: integers in, decimal text out.
// Depends on sida_pkg and the RTL of the converter; carries its own text predictor
// and runs directed edge values followed by random values under four idling phases.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDTH         = 32;
  localparam int ITEMS_PER_MIX = 25;   // four random phases plus the edge values, about 120
  localparam int SETTLE_CYCLES = 64;   // one full conversion plus margin

  // One character of the expected text and its end-of-value flag
  typedef struct packed {
    logic [7:0] text_char;
    logic       is_last;
  } text_char_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [WIDTH-1:0] in_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_text_char;
  logic             out_is_last;

  text_char_t pending_text[$];   // characters still owed by the converter, oldest first
  text_char_t owed_char;
  int         error_count = 0;
  int         sender_idle_pct = 0;
  int         receiver_stall_pct = 0;

  signed_int_to_decimal_ascii #(.VALUE_WIDTH(WIDTH)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_text_char (out_text_char),
    .out_is_last   (out_is_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest correct run (one conversion per value
  // plus stalls on up to eleven characters and the sender's gaps).
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Work out the text of one value: optional '-' then the digits of the
  // magnitude, most significant first. The magnitude is held unsigned so the
  // most negative value gives 2147483648 rather than wrapping.
  function automatic void predict_text(logic [WIDTH-1:0] value);
    logic [WIDTH-1:0] magnitude;
    logic [7:0]       digits[$];
    text_char_t       ch;
    magnitude = value[WIDTH-1] ? (~value + 1'b1) : value;
    do begin
      digits.push_front(sida_pkg::CHAR_ZERO + 8'(magnitude % 10));
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (value[WIDTH-1]) begin
      ch.text_char = sida_pkg::CHAR_MINUS;
      ch.is_last   = 1'b0;
      pending_text.push_back(ch);
    end
    foreach (digits[i]) begin
      ch.text_char = digits[i];
      ch.is_last   = (i == digits.size() - 1);
      pending_text.push_back(ch);
    end
  endfunction

  function automatic longint ten_to(int unsigned power);
    longint result;
    result = 1;
    repeat (power) result = result * 10;
    return result;
  endfunction

  // Draw a value. A quarter are raw 32-bit words, so every input bit toggles;
  // the rest pick a digit count first so short and long texts are equally
  // common, with some landing exactly on the edges of a digit count.
  function automatic logic [WIDTH-1:0] pick_value();
    int unsigned kind;
    int unsigned ndig;
    bit          negative;
    longint      lo;
    longint      hi;
    longint      magnitude;
    kind     = $urandom_range(0, 3);
    negative = $urandom_range(0, 1);
    if (kind == 0)
      return $urandom;
    ndig = $urandom_range(1, 10);
    lo   = (ndig == 1) ? 0 : ten_to(ndig - 1);
    hi   = ten_to(ndig) - 1;
    if (hi > 64'sd2147483648)
      hi = 64'sd2147483648;
    if (kind == 3)
      magnitude = $urandom_range(0, 1) ? lo : hi;
    else
      magnitude = lo + longint'({$urandom, $urandom} % (hi - lo + 1));
    if (!negative && magnitude > 64'sd2147483647)
      magnitude = 64'sd2147483647;
    return negative ? WIDTH'(-magnitude) : WIDTH'(magnitude);
  endfunction

  // Present one value, hold it until accepted, then idle the sender for a
  // random stretch if the current phase asks for it. With no gap, valid stays
  // high and the next call simply replaces the payload in the same step.
  task automatic send_value(logic [WIDTH-1:0] value);
    in_valid <= 1'b1;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_text(value);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
  endtask

  // Drop valid, wait for every owed character, then let the converter settle
  // so that any stray extra character would still be caught.
  task automatic drain_text();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_values(int idle_pct, int stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (ITEMS_PER_MIX) send_value(pick_value());
    drain_text();
  endtask

  // Zero, one-digit values, several digit-count boundaries, both ends of the range
  // including the most negative value, and alternating bit patterns.
  task automatic test_edge_values();
    logic [WIDTH-1:0] edge_values[$];
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    edge_values = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
                    32'sd99, 32'sd100, 32'sd999999999, 32'sd1000000000,
                    -32'sd999999999, -32'sd1000000000, 32'sd2147483647,
                    -32'sd2147483647, 32'h8000_0000, 32'h5555_5555,
                    32'hAAAA_AAAA, 32'sd12345, -32'sd67890};
    foreach (edge_values[i]) send_value(edge_values[i]);
    drain_text();
  endtask

  task automatic test_back_to_back();
    run_random_values(0, 0);
  endtask

  task automatic test_sender_gaps();
    run_random_values(49, 0);
  endtask

  task automatic test_receiver_stalls();
    run_random_values(0, 49);
  endtask

  task automatic test_both_sides_idle();
    run_random_values(11, 11);
  endtask

  // Compare each character taken from the converter with the oldest owed one,
  // then choose whether to take a character on the next edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_text.size() == 0) begin
        $error("unexpected character: text_char=%h is_last=%b", out_text_char, out_is_last);
        error_count++;
      end else begin
        owed_char = pending_text.pop_front();
        if (out_text_char !== owed_char.text_char) begin
          $error("text_char: expected %h, got %h", owed_char.text_char, out_text_char);
          error_count++;
        end
        if (out_is_last !== owed_char.is_last) begin
          $error("is_last: expected %b, got %b", owed_char.is_last, out_is_last);
          error_count++;
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_values();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();

    if (error_count == 0 && pending_text.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
